FILE: sv/key_debounce_long_press_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for key_debounce_long_press
// Concurrent checks on clock and active-low reset; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`ifndef SYNTHESIS
`define KDLP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("kdlp assertion failed");
`define KDLP_ASSERT_NEVER(lbl, clk, rstn, cond) \
	`KDLP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define KDLP_ASSERT(lbl, clk, rstn, prop)
`define KDLP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: sv/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants of the key debounce / long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

	localparam int TICK_WIDTH_DEF = 32;

	localparam int          LPT_WIDTH      = 32;
	localparam int          DBS_WIDTH      = 4;
	localparam logic [31:0] LPT_RESET      = 32'd1000;
	localparam logic [3:0]  DBS_RESET      = 4'd4;
	localparam int          APB_ADDR_WIDTH = 3;

	// register index, taken from paddr[2]
	localparam logic REG_LONG_PRESS = 1'b0;
	localparam logic REG_DEBOUNCE   = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PRESSED = 2'd1,
		MODE_LONG    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_RUN  = 2'd1,
		CMD_JOG  = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [LPT_WIDTH-1:0] long_press_ticks;
		logic [DBS_WIDTH-1:0] debounce_samples;
	} cfg_t;

	typedef struct packed {
		cmd_t  cmd;
		mode_t mode;
		logic  led;
	} key_res_t;

endpackage

FILE: sv/kdlp_cfg.sv
// ----------------------------------------------------------------------------
// kdlp_cfg
// APB register file: long-press threshold and debounce sample count.
// ----------------------------------------------------------------------------
module kdlp_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kdlp_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output kdlp_pkg::cfg_t                      cfg
);

	kdlp_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= kdlp_pkg::LPT_RESET;
			cfg_q.debounce_samples <= kdlp_pkg::DBS_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				kdlp_pkg::REG_LONG_PRESS: begin
					cfg_q.long_press_ticks <= pwdata;
				end
				kdlp_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_samples <= pwdata[kdlp_pkg::DBS_WIDTH-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			kdlp_pkg::REG_LONG_PRESS: begin
				prdata = cfg_q.long_press_ticks;
			end
			kdlp_pkg::REG_DEBOUNCE: begin
				prdata = {28'd0, cfg_q.debounce_samples};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/kdlp_key.sv
// ----------------------------------------------------------------------------
// kdlp_key
// One key: debounce counter plus idle / pressed / long-pressed machine.
// ----------------------------------------------------------------------------
`include "key_debounce_long_press_assert.svh"

module kdlp_key #(
	parameter int TICK_WIDTH = kdlp_pkg::TICK_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    pressed,
	input  logic [TICK_WIDTH-1:0]   now,
	input  kdlp_pkg::cfg_t          cfg,
	output kdlp_pkg::key_res_t      res
);

	localparam int CMP_W = (TICK_WIDTH > kdlp_pkg::LPT_WIDTH) ? TICK_WIDTH
		: kdlp_pkg::LPT_WIDTH;

	kdlp_pkg::mode_t                   mode_q, mode_d;
	logic [TICK_WIDTH-1:0]             start_q, start_d;
	logic [kdlp_pkg::DBS_WIDTH-1:0]    cnt_q, cnt_d, cnt_inc;
	logic                              last_q, last_d;
	logic                              led_q, led_d;
	logic [TICK_WIDTH-1:0]             dur;
	logic                              is_long;
	kdlp_pkg::cmd_t                    cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= kdlp_pkg::MODE_IDLE;
			start_q <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			led_q   <= 1'b0;
		end else if (en) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
			led_q   <= led_d;
		end
	end

	always_comb begin
		cnt_inc = cnt_q;
		if (cnt_q < cfg.debounce_samples)
			cnt_inc = cnt_q + 4'd1;
		// press time, wrapping at the tick width
		dur     = now - start_q;
		is_long = CMP_W'(dur) >= CMP_W'(cfg.long_press_ticks);

		mode_d  = mode_q;
		start_d = start_q;
		cnt_d   = cnt_q;
		last_d  = last_q;
		led_d   = led_q;
		cmd     = kdlp_pkg::CMD_NONE;

		if (pressed != last_q) begin
			cnt_d  = '0;
			last_d = pressed;
		end else begin
			cnt_d = cnt_inc;
			if (cnt_inc >= cfg.debounce_samples) begin
				case (mode_q)
					kdlp_pkg::MODE_IDLE: begin
						if (pressed) begin
							mode_d  = kdlp_pkg::MODE_PRESSED;
							start_d = now;
						end
					end
					kdlp_pkg::MODE_PRESSED: begin
						if (pressed) begin
							if (is_long) begin
								mode_d = kdlp_pkg::MODE_LONG;
								led_d  = 1'b1;
								cmd    = kdlp_pkg::CMD_RUN;
							end
						end else begin
							mode_d = kdlp_pkg::MODE_IDLE;
							if (!is_long)
								cmd = kdlp_pkg::CMD_JOG;
						end
					end
					kdlp_pkg::MODE_LONG: begin
						if (!pressed) begin
							mode_d = kdlp_pkg::MODE_IDLE;
							led_d  = 1'b0;
							cmd    = kdlp_pkg::CMD_STOP;
						end
					end
					default: begin
						mode_d = kdlp_pkg::MODE_IDLE;
					end
				endcase
			end
		end

		res.cmd  = cmd;
		res.mode = mode_d;
		res.led  = led_d;
	end

	// LED is lit exactly while the key sits in long press
	`KDLP_ASSERT_NEVER(a_led_long, clk, arst_n, led_q != (mode_q == kdlp_pkg::MODE_LONG))
	`KDLP_ASSERT(a_lvl_clr, clk, arst_n, en && (pressed != last_q) |=> cnt_q == '0 && last_q == $past(pressed))
	`KDLP_ASSERT(a_run_long, clk, arst_n, en && (cmd == kdlp_pkg::CMD_RUN) |=> mode_q == kdlp_pkg::MODE_LONG && led_q)

endmodule

FILE: sv/key_debounce_long_press.sv
// Path: an accepted input transaction goes to the input register, then its result to m_tdata.
// Throughput: one scan per cycle; input register, one pass of key logic, result register.
// Backpressure on m_tready stalls both stages; s_tready stays high while the result moves.
// Reset (arst_n low, asynchronous): both keys idle, counts and levels cleared, LEDs off,
//   long_press_ticks = 1000, debounce_samples = 4, no valid data in either stage.
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Two-key scanner with debounce and long-press detection for jog/run control.
// ----------------------------------------------------------------------------
module key_debounce_long_press #(
	parameter int TICK_WIDTH = kdlp_pkg::TICK_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: [0] fwd_pin_level, [1] rev_pin_level, [TICK_WIDTH+1:2] tick_now
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((TICK_WIDTH+2+7)/8)*8-1:0]   s_tdata,
	// m_tdata: [1:0] fwd_motor_cmd, [3:2] rev_motor_cmd, [5:4] fwd_key_mode,
	//          [7:6] rev_key_mode, [8] fwd_led, [9] rev_led
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kdlp_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	kdlp_pkg::cfg_t        cfg;
	logic                  valid_s1;
	logic                  fwd_pressed_s1, rev_pressed_s1;
	logic [TICK_WIDTH-1:0] tick_s1;
	logic                  valid_s2;
	logic [9:0]            data_s2;
	logic                  adv, en;
	kdlp_pkg::key_res_t    fwd_res, rev_res;

	assign adv      = !valid_s2 || m_tready;
	assign en       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// pins are active low
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			fwd_pressed_s1 <= !s_tdata[0];
			rev_pressed_s1 <= !s_tdata[1];
			tick_s1        <= s_tdata[TICK_WIDTH+1:2];
		end
	end

	kdlp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kdlp_key #(.TICK_WIDTH(TICK_WIDTH)) u_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.pressed (fwd_pressed_s1),
		.now     (tick_s1),
		.cfg     (cfg),
		.res     (fwd_res)
	);

	kdlp_key #(.TICK_WIDTH(TICK_WIDTH)) u_rev (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.pressed (rev_pressed_s1),
		.now     (tick_s1),
		.cfg     (cfg),
		.res     (rev_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= {rev_res.led, fwd_res.led, rev_res.mode, fwd_res.mode,
				rev_res.cmd, fwd_res.cmd};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, data_s2};

endmodule

FILE: bench/key_debounce_long_press_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_test
// Drives scan transactions into the two-key scanner and checks every result
// against an in-bench model of the debounce counters and key state machines.
// Covers directed jog / run / stop / wrap cases, then random key sequences
// under several register settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module key_debounce_long_press_test;

	localparam logic [kdlp_pkg::APB_ADDR_WIDTH-1:0] ADDR_LONG_PRESS =
		{kdlp_pkg::REG_LONG_PRESS, 2'b00};
	localparam logic [kdlp_pkg::APB_ADDR_WIDTH-1:0] ADDR_DEBOUNCE   =
		{kdlp_pkg::REG_DEBOUNCE, 2'b00};

	class scan_scoreboard;
		kdlp_pkg::mode_t key_state[2];
		logic [31:0]     press_tick[2];
		logic [3:0]      sample_cnt[2];
		logic            held_level[2];
		logic            led[2];
		logic [31:0]     long_ticks;
		logic [3:0]      settle_samples;
		logic [15:0]     pending[$];
		int              mismatches;

		function new();
			for (int k = 0; k < 2; k++) begin
				key_state[k]  = kdlp_pkg::MODE_IDLE;
				press_tick[k] = '0;
				sample_cnt[k] = '0;
				held_level[k] = 1'b0;
				led[k]        = 1'b0;
			end
			long_ticks     = kdlp_pkg::LPT_RESET;
			settle_samples = kdlp_pkg::DBS_RESET;
			mismatches     = 0;
		endfunction

		function kdlp_pkg::cmd_t key_step(int k, logic pressed, logic [31:0] now);
			logic [31:0] held;
			if (pressed != held_level[k]) begin
				sample_cnt[k] = '0;
				held_level[k] = pressed;
				return kdlp_pkg::CMD_NONE;
			end
			if (sample_cnt[k] < settle_samples)
				sample_cnt[k] = sample_cnt[k] + 4'd1;
			if (sample_cnt[k] < settle_samples)
				return kdlp_pkg::CMD_NONE;
			held = now - press_tick[k];
			case (key_state[k])
				kdlp_pkg::MODE_IDLE: begin
					if (pressed) begin
						key_state[k]  = kdlp_pkg::MODE_PRESSED;
						press_tick[k] = now;
					end
					return kdlp_pkg::CMD_NONE;
				end
				kdlp_pkg::MODE_PRESSED: begin
					if (pressed) begin
						if (held >= long_ticks) begin
							key_state[k] = kdlp_pkg::MODE_LONG;
							led[k]       = 1'b1;
							return kdlp_pkg::CMD_RUN;
						end
						return kdlp_pkg::CMD_NONE;
					end
					key_state[k] = kdlp_pkg::MODE_IDLE;
					return (held < long_ticks) ? kdlp_pkg::CMD_JOG : kdlp_pkg::CMD_NONE;
				end
				kdlp_pkg::MODE_LONG: begin
					if (!pressed) begin
						key_state[k] = kdlp_pkg::MODE_IDLE;
						led[k]       = 1'b0;
						return kdlp_pkg::CMD_STOP;
					end
					return kdlp_pkg::CMD_NONE;
				end
				default: begin
					key_state[k] = kdlp_pkg::MODE_IDLE;
					return kdlp_pkg::CMD_NONE;
				end
			endcase
		endfunction

		// pins are active low
		function void note_scan(logic fwd_pin, logic rev_pin, logic [31:0] now);
			kdlp_pkg::cmd_t fwd_cmd;
			kdlp_pkg::cmd_t rev_cmd;
			fwd_cmd = key_step(0, ~fwd_pin, now);
			rev_cmd = key_step(1, ~rev_pin, now);
			pending.push_back({6'b0, led[1], led[0], key_state[1], key_state[0],
				rev_cmd, fwd_cmd});
		endfunction

		function void check_result(logic [15:0] got);
			logic [15:0] want;
			int          lsb;
			int          mask;
			string       names[6];
			names = '{"fwd_motor_cmd", "rev_motor_cmd", "fwd_key_mode", "rev_key_mode",
				"fwd_led", "rev_led"};
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending, m_tdata=%h", $realtime, got);
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 6; i++) begin
				lsb  = (i < 4) ? 2 * i : 4 + i;
				mask = (i < 4) ? 3 : 1;
				if (((got >> lsb) & mask) !== ((want >> lsb) & mask)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: %s mismatch, expected %0d got %0d", $realtime,
							names[i], (want >> lsb) & mask, (got >> lsb) & mask);
				end
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [39:0]                         s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [15:0]                         m_tdata;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [kdlp_pkg::APB_ADDR_WIDTH-1:0] paddr;
	logic [31:0]                         pwdata;
	logic [31:0]                         prdata;
	logic                                pready;

	scan_scoreboard sb;
	int             idle_pct;
	int             stall_pct;
	int             hold_left;
	logic           gen_level[2];
	int             run_left[2];
	logic [31:0]    gen_tick;

	key_debounce_long_press DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("key_debounce_long_press_test failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	task send_scan(logic fwd_pin, logic rev_pin, logic [31:0] now);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, now, rev_pin, fwd_pin};
		do @(posedge clk); while (!s_tready);
		sb.note_scan(fwd_pin, rev_pin, now);
		@(negedge clk);
	endtask

	task wait_drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task apb_access(logic wr, logic [kdlp_pkg::APB_ADDR_WIDTH-1:0] addr,
			logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// only called with the block drained
	task set_config(logic [31:0] lpt, logic [3:0] dbs);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_LONG_PRESS, lpt, rd);
		apb_access(1'b1, ADDR_DEBOUNCE, {28'b0, dbs}, rd);
		sb.long_ticks     = lpt;
		sb.settle_samples = dbs;
		apb_access(1'b0, ADDR_LONG_PRESS, '0, rd);
		if (rd !== lpt) begin
			sb.mismatches++;
			if (sb.mismatches <= 10)
				$display("long_press_ticks readback: expected %h got %h", lpt, rd);
		end
		apb_access(1'b0, ADDR_DEBOUNCE, '0, rd);
		if (rd !== {28'b0, dbs}) begin
			sb.mismatches++;
			if (sb.mismatches <= 10)
				$display("debounce_samples readback: expected %h got %h", dbs, rd);
		end
	endtask

	// Random key activity: stable holds of random length mixed with bounces,
	// tick advancing in random steps of up to step_max, with occasional random jumps.
	task run_phase(int n, int idle, int stall, logic [31:0] lpt, logic [3:0] dbs,
			logic [31:0] step_max, bit hold_off, bit pause_mid);
		logic pin[2];
		wait_drain();
		set_config(lpt, dbs);
		idle_pct  = idle;
		stall_pct = stall;
		if (hold_off) begin
			@(posedge clk);
			hold_left = 80;
			@(negedge clk);
		end
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				wait_drain();
			for (int k = 0; k < 2; k++) begin
				if (run_left[k] == 0) begin
					gen_level[k] = ~gen_level[k];
					run_left[k]  = ($urandom_range(3) == 0) ? $urandom_range(1, 2)
						: $urandom_range(1, dbs + 12);
				end
				run_left[k]--;
				pin[k] = ($urandom_range(15) == 0) ? 1'($urandom_range(1)) : ~gen_level[k];
			end
			if ($urandom_range(19) == 0)
				gen_tick = $urandom();
			else
				gen_tick = gen_tick + $urandom_range(0, step_max);
			send_scan(pin[0], pin[1], gen_tick);
		end
	endtask

	initial begin
		sb        = new();
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 0;
		gen_level = '{1'b0, 1'b0};
		run_left  = '{0, 0};
		gen_tick  = 32'h0000_1000;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: both keys walk the same path, pins active low
		set_config(32'd1000, 4'd0);
		send_scan(1'b0, 1'b0, 32'd100);     // level change
		send_scan(1'b0, 1'b0, 32'd100);     // zero debounce: idle -> pressed
		send_scan(1'b1, 1'b1, 32'd200);
		send_scan(1'b1, 1'b1, 32'd300);     // short release: jog
		send_scan(1'b0, 1'b0, 32'd400);
		send_scan(1'b0, 1'b0, 32'd500);
		send_scan(1'b0, 1'b0, 32'd1499);    // one tick short of long press
		send_scan(1'b0, 1'b0, 32'd1500);    // run, LED on
		send_scan(1'b1, 1'b1, 32'd1600);
		send_scan(1'b1, 1'b1, 32'd1600);    // stop, LED off
		send_scan(1'b0, 1'b0, 32'd2000);
		send_scan(1'b0, 1'b0, 32'd2000);
		send_scan(1'b1, 1'b1, 32'd2500);
		send_scan(1'b1, 1'b1, 32'd5000);    // late release from pressed: no command
		wait_drain();
		// max threshold reached only through wraparound of the tick
		set_config(32'hFFFF_FFFF, 4'd0);
		send_scan(1'b0, 1'b0, 32'hFFFF_FFF0);
		send_scan(1'b0, 1'b0, 32'hFFFF_FFF0);
		send_scan(1'b0, 1'b0, 32'h0000_0000);
		send_scan(1'b0, 1'b0, 32'hFFFF_FFEF);
		send_scan(1'b1, 1'b1, 32'hFFFF_FFFF);
		send_scan(1'b1, 1'b1, 32'hFFFF_FFFF);

		run_phase(190, 0, 0, kdlp_pkg::LPT_RESET, kdlp_pkg::DBS_RESET, 32'd300, 1'b0, 1'b1);
		run_phase(190, 85, 0, 32'd1, 4'd0, 32'd1, 1'b0, 1'b0);
		run_phase(190, 0, 85, 32'd50, 4'd15, 32'd20, 1'b0, 1'b0);
		run_phase(190, 23, 23, 32'($urandom_range(1, 500)), 4'($urandom_range(15)),
			32'd40, 1'b0, 1'b0);
		run_phase(190, 0, 0, 32'hFFFF_FFFF, 4'd2, 32'h4000_0000, 1'b1, 1'b0);

		wait_drain();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("key_debounce_long_press_test passed");
		else
			$display("key_debounce_long_press_test failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/kdlp_pkg.sv
sv/kdlp_cfg.sv
sv/kdlp_key.sv
sv/key_debounce_long_press.sv
bench/key_debounce_long_press_test.sv
